>>> hw/rtl/sgdm_pkg.sv
package sgdm_pkg;

    localparam int INDEX_W    = 12;
    localparam int DATA_W     = 32;
    localparam int LR_W       = 24;
    localparam int BETA_W     = 16;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MOMENTUM_FACTOR = 1'd1;

    localparam logic [LR_W-1:0]   LR_RESET   = 24'd655;
    localparam logic [BETA_W-1:0] BETA_RESET = 16'd58982;

    // 1.0 in Q1.16
    localparam logic [BETA_W:0] Q_ONE = 17'd65536;

    // operation codes
    localparam logic OP_CLEAR  = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    typedef struct packed {
        logic                     operation;
        logic [INDEX_W-1:0]       entry_index;
        logic signed [DATA_W-1:0] gradient;
    } sgdm_in_t;

    typedef struct packed {
        logic [INDEX_W-1:0]       result_index;
        logic signed [DATA_W-1:0] delta;
    } sgdm_out_t;

endpackage

>>> hw/rtl/sgdm_ram.sv
module sgdm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/sgd_momentum_update.sv
// Channel  Dir  Payload          Handshake
// s_       in   sgdm_in_t        s_valid / s_ready
// m_       out  sgdm_out_t       m_valid / m_ready
// cfg_     in   index, data      cfg_wr_en, no wait
//
// One item at a time, run by a sequencer around the momentum RAM: an update
// steps through accept, index map, RAM read, mix multiply, sum and round,
// write-back with the lr multiply, and output load; a clear steps through
// accept, index map and the clear write. The single RAM port and the chain
// of two dependent multiplies set the length of the update sequence. The
// result sits in an output register, so the next word is accepted while it
// waits; a stalled m_ready holds the sequencer only at the output load. Reset
// is synchronous; momentum entries are undefined until cleared or updated.
module sgd_momentum_update #(
    parameter int ENTRIES = 4096
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  sgdm_pkg::sgdm_in_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output sgdm_pkg::sgdm_out_t                 m_data,
    input  logic                                cfg_wr_en,
    input  logic [sgdm_pkg::CFG_IDX_W-1:0]      cfg_wr_index,
    input  logic [sgdm_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);

    import sgdm_pkg::*;

    localparam int ADDR_W = $clog2(ENTRIES);

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_ADDR    = 8'b0000_0010,
        ST_CLEAR   = 8'b0000_0100,
        ST_READ    = 8'b0000_1000,
        ST_MIX_MUL = 8'b0001_0000,
        ST_MIX_SUM = 8'b0010_0000,
        ST_LR_MUL  = 8'b0100_0000,
        ST_OUT     = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [LR_W-1:0]          lr_reg;
    logic [BETA_W-1:0]        beta_reg;
    logic                     op_reg;
    logic [INDEX_W-1:0]       idx_reg;
    logic signed [DATA_W-1:0] grad_reg;
    logic [ADDR_W-1:0]        addr_map;
    logic [ADDR_W-1:0]        addr_reg;
    logic signed [49:0]       p_grad_reg;
    logic signed [48:0]       p_mom_reg;
    logic signed [DATA_W-1:0] mnew_reg;
    logic signed [56:0]       prod_reg;
    logic                     m_valid_reg;
    sgdm_out_t                m_data_reg;

    logic                     s_accept;
    logic                     out_free;
    logic [BETA_W:0]          one_minus_beta;
    logic signed [49:0]       p_grad_next;
    logic signed [48:0]       p_mom_next;
    logic signed [57:0]       mix;
    logic signed [DATA_W-1:0] mnew_next;
    logic signed [56:0]       prod_next;
    logic signed [DATA_W-1:0] delta_next;

    logic                     ram_we;
    logic                     ram_re;
    logic [DATA_W-1:0]        ram_wdata;
    logic [DATA_W-1:0]        ram_rdata;

    // round to nearest (ties up) after dropping 16 fraction bits, then clamp
    function automatic logic signed [DATA_W-1:0] round_sat(input logic signed [57:0] v);
        logic signed [57:0] r;
        logic               fits;
        r    = (v + 58'sd32768) >>> 16;
        fits = (r[57:DATA_W-1] == '0) || (r[57:DATA_W-1] == '1);
        if (fits) begin
            round_sat = r[DATA_W-1:0];
        end else if (r[57]) begin
            round_sat = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            round_sat = {1'b0, {(DATA_W-1){1'b1}}};
        end
    endfunction

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // entry index to store address
    generate
        if (ENTRIES >= (1 << INDEX_W)) begin : g_addr_wide
            assign addr_map = ADDR_W'(idx_reg);
        end else if ((ENTRIES & (ENTRIES - 1)) == 0) begin : g_addr_pow2
            assign addr_map = idx_reg[ADDR_W-1:0];
        end else begin : g_addr_recip
            localparam int RECIP_SHIFT = 2 * INDEX_W;
            localparam int RECIP = ((1 << RECIP_SHIFT) + ENTRIES - 1) / ENTRIES;
            localparam int PROD_W = INDEX_W + RECIP_SHIFT;
            localparam int QUOT_W = INDEX_W - 4;
            localparam int QE_W = INDEX_W + QUOT_W;

            logic [PROD_W-1:0]  quot_prod;
            logic [QUOT_W-1:0]  quot_reg;
            logic [QE_W-1:0]    quot_e;
            logic [INDEX_W-1:0] rem;

            // exact quotient, any 12-bit index, ENTRIES>15: idx*ceil(2^24/ENTRIES)
            assign quot_prod = PROD_W'(s_data.entry_index) * PROD_W'(RECIP);

            always_ff @(posedge aclk) begin
                if (s_accept) begin
                    quot_reg <= quot_prod[RECIP_SHIFT +: QUOT_W];
                end
            end

            assign quot_e   = QE_W'(quot_reg) * QE_W'(ENTRIES);
            assign rem      = idx_reg - quot_e[INDEX_W-1:0];
            assign addr_map = rem[ADDR_W-1:0];
        end
    endgenerate

    assign one_minus_beta = Q_ONE - {1'b0, beta_reg};
    assign p_grad_next    = $signed({1'b0, one_minus_beta}) * grad_reg;
    assign p_mom_next     = $signed({1'b0, beta_reg}) * $signed(ram_rdata);
    assign mix            = 58'(p_grad_reg) + 58'(p_mom_reg);
    assign mnew_next      = round_sat(mix);
    assign prod_next      = $signed({1'b0, lr_reg}) * mnew_reg;
    assign delta_next     = round_sat(-58'(prod_reg));

    assign ram_we    = (state_reg == ST_CLEAR) || (state_reg == ST_LR_MUL);
    assign ram_re    = (state_reg == ST_READ);
    assign ram_wdata = (state_reg == ST_CLEAR) ? '0 : mnew_reg;

    sgdm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (ENTRIES)
    ) u_momentum_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (addr_reg),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (s_accept) state_next = ST_ADDR;
            ST_ADDR:    state_next = (op_reg == OP_UPDATE) ? ST_READ : ST_CLEAR;
            ST_CLEAR:   state_next = ST_IDLE;
            ST_READ:    state_next = ST_MIX_MUL;
            ST_MIX_MUL: state_next = ST_MIX_SUM;
            ST_MIX_SUM: state_next = ST_LR_MUL;
            ST_LR_MUL:  state_next = ST_OUT;
            ST_OUT:     if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            lr_reg      <= LR_RESET;
            beta_reg    <= BETA_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    REG_LEARNING_RATE:   lr_reg   <= cfg_wr_data[LR_W-1:0];
                    REG_MOMENTUM_FACTOR: beta_reg <= cfg_wr_data[BETA_W-1:0];
                    default: ;
                endcase
            end
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg   <= s_data.operation;
            idx_reg  <= s_data.entry_index;
            grad_reg <= s_data.gradient;
        end
        if (state_reg == ST_ADDR) begin
            addr_reg <= addr_map;
        end
        if (state_reg == ST_MIX_MUL) begin
            p_grad_reg <= p_grad_next;
            p_mom_reg  <= p_mom_next;
        end
        if (state_reg == ST_MIX_SUM) begin
            mnew_reg <= mnew_next;
        end
        if (state_reg == ST_LR_MUL) begin
            prod_reg <= prod_next;
        end
        if (state_reg == ST_OUT && out_free) begin
            m_data_reg.result_index <= idx_reg;
            m_data_reg.delta        <= delta_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef NO_ASSERTIONS
    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && out_free) |=> m_valid_reg)
        else $error("result word not presented after load");

    a_clear_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |=> !$rose(m_valid_reg))
        else $error("clear produced a result word");

    a_port_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> !ram_re)
        else $error("momentum RAM read and written in one cycle");

    a_accept_start: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> state_reg == ST_ADDR)
        else $error("accepted word did not start the sequence");

    a_read_first: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MIX_MUL) |-> $past(state_reg) == ST_READ)
        else $error("momentum used without a preceding read");
`endif

endmodule
